// ===== rtl/core/udt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the UDP port demux table.
// No dependencies; imported by every module of the block.
package udt_pkg;

    // Request kinds
    localparam logic [1:0] REQ_DELIVER = 2'd0;
    localparam logic [1:0] REQ_CONNECT = 2'd1;
    localparam logic [1:0] REQ_LISTEN  = 2'd2;
    localparam logic [1:0] REQ_CLOSE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSLOT  = 2'd1;
    localparam logic [1:0] ST_NOSOCK  = 2'd2;
    localparam logic [1:0] ST_UNREACH = 2'd3;

    // Only IPv4 addresses are taken by connect
    localparam logic [7:0] ADDR_LEN_IPV4 = 8'd4;

    // One slot's stored words
    typedef struct packed {
        logic [15:0] own_port;
        logic [31:0] far_ip;
        logic [15:0] far_port;
    } slot_entry_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [15:0] own_port;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
    } result_t;

endpackage

// ===== rtl/core/udt_slot_mem.sv =====
`timescale 1ns / 1ps
// Slot table memory: one write port, one read port, registered read data.
// Depends on udt_pkg for the entry type.
module udt_slot_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  udt_pkg::slot_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output udt_pkg::slot_entry_t rd_data
);
    import udt_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/udt_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer: slot flags, table scan, read-modify-write of the slot
// memory and the registered result. Depends on udt_pkg.
module udt_ctrl #(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3,
    parameter int CNT_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          port_base,
    input  logic [1:0]           req_type,
    input  logic [15:0]          packet_dest_port,
    input  logic [15:0]          packet_src_port,
    input  logic [31:0]          packet_src_ip,
    input  logic [31:0]          connect_ip,
    input  logic [15:0]          connect_port,
    input  logic [7:0]           addr_length,
    input  logic [15:0]          listen_port,
    input  logic [2:0]           close_slot,
    output logic                 mem_wr_en,
    output logic [IDX_W-1:0]     mem_wr_addr,
    output udt_pkg::slot_entry_t mem_wr_data,
    output logic                 mem_rd_en,
    output logic [IDX_W-1:0]     mem_rd_addr,
    input  udt_pkg::slot_entry_t mem_rd_data,
    output logic                 done,
    output udt_pkg::result_t     result
);
    import udt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Scan position and read pipeline
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_used_reg, rd_used_next;
    logic             rd_client_reg, rd_client_next;
    logic             rd_server_reg, rd_server_next;

    // Per-slot flags
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] client_reg, client_next;
    logic [SLOTS-1:0] server_reg, server_next;

    // Latched request
    logic [1:0]  req_reg;
    logic [15:0] dport_reg;
    logic [15:0] sport_reg;
    logic [31:0] sip_reg;
    logic [31:0] cip_reg;
    logic [15:0] cport_reg;
    logic [7:0]  alen_reg;
    logic [15:0] lport_reg;
    logic [2:0]  close_reg;

    // Result register
    logic    done_reg, done_next;
    result_t res_reg, res_next;

    logic             accept;
    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] close_idx;
    logic             exhausted;
    logic             close_bad;
    logic             hit;
    logic [15:0]      new_port;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg == S_SCAN);
    assign scan_idx  = idx_reg[IDX_W-1:0];
    assign close_idx = IDX_W'(close_reg);
    assign exhausted = (idx_reg == CNT_W'(SLOTS));
    assign close_bad = (int'(close_reg) >= SLOTS);
    assign hit       = rd_vld_reg && rd_used_reg && (mem_rd_data.own_port == dport_reg);
    assign new_port  = 16'(port_base + 16'(scan_idx));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rd_used_next   = rd_used_reg;
        rd_client_next = rd_client_reg;
        rd_server_next = rd_server_reg;
        used_next      = used_reg;
        client_next    = client_reg;
        server_next    = server_reg;
        done_next      = 1'b0;
        res_next       = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = scan_idx;
        mem_wr_data    = '0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                case (req_reg) inside
                    REQ_CLOSE:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                        if (close_bad)
                        begin
                            res_next.status = ST_NOSOCK;
                        end
                        else
                        begin
                            used_next[close_idx]   = 1'b0;
                            client_next[close_idx] = 1'b0;
                            server_next[close_idx] = 1'b0;
                            res_next.status        = ST_OK;
                            res_next.slot          = close_reg;
                        end
                    end
                    REQ_CONNECT, REQ_LISTEN:
                    begin
                        if ((req_reg == REQ_CONNECT && alen_reg != ADDR_LEN_IPV4) || exhausted)
                        begin
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                            res_next.status = ST_NOSLOT;
                        end
                        else if (!used_reg[scan_idx])
                        begin
                            // First free slot: claim it
                            done_next            = 1'b1;
                            state_next           = S_IDLE;
                            mem_wr_en            = 1'b1;
                            used_next[scan_idx]  = 1'b1;
                            res_next.status      = ST_OK;
                            res_next.slot        = 3'(scan_idx);
                            if (req_reg == REQ_CONNECT)
                            begin
                                client_next[scan_idx] = 1'b1;
                                mem_wr_data.own_port  = new_port;
                                mem_wr_data.far_ip    = cip_reg;
                                mem_wr_data.far_port  = cport_reg;
                                res_next.own_port     = new_port;
                                res_next.peer_ip      = cip_reg;
                                res_next.peer_port    = cport_reg;
                            end
                            else
                            begin
                                server_next[scan_idx] = 1'b1;
                                mem_wr_data.own_port  = lport_reg;
                                res_next.own_port     = lport_reg;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        // Deliver: pipelined port match, first hit decides
                        if (hit)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                            if (rd_client_reg)
                            begin
                                if (mem_rd_data.far_ip == sip_reg)
                                begin
                                    res_next.status    = ST_OK;
                                    res_next.slot      = 3'(rd_idx_reg);
                                    res_next.own_port  = mem_rd_data.own_port;
                                    res_next.peer_ip   = mem_rd_data.far_ip;
                                    res_next.peer_port = mem_rd_data.far_port;
                                end
                                else
                                begin
                                    res_next.status = ST_NOSOCK;
                                end
                            end
                            else if (rd_server_reg)
                            begin
                                // Server learns the sender
                                mem_wr_en            = 1'b1;
                                mem_wr_addr          = rd_idx_reg;
                                mem_wr_data.own_port = mem_rd_data.own_port;
                                mem_wr_data.far_ip   = sip_reg;
                                mem_wr_data.far_port = sport_reg;
                                res_next.status      = ST_OK;
                                res_next.slot        = 3'(rd_idx_reg);
                                res_next.own_port    = mem_rd_data.own_port;
                                res_next.peer_ip     = sip_reg;
                                res_next.peer_port   = sport_reg;
                            end
                            else
                            begin
                                res_next.status = ST_NOSOCK;
                            end
                        end
                        else if (exhausted && !rd_vld_reg)
                        begin
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                            res_next.status = ST_UNREACH;
                        end
                        else if (!exhausted)
                        begin
                            mem_rd_en      = 1'b1;
                            rd_vld_next    = 1'b1;
                            rd_idx_next    = scan_idx;
                            rd_used_next   = used_reg[scan_idx];
                            rd_client_next = client_reg[scan_idx];
                            rd_server_next = server_reg[scan_idx];
                            idx_next       = idx_reg + 1'b1;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            used_reg   <= '0;
            client_reg <= '0;
            server_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            used_reg   <= used_next;
            client_reg <= client_next;
            server_reg <= server_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        rd_used_reg   <= rd_used_next;
        rd_client_reg <= rd_client_next;
        rd_server_reg <= rd_server_next;
        res_reg       <= res_next;
        if (accept)
        begin
            req_reg   <= req_type;
            dport_reg <= packet_dest_port;
            sport_reg <= packet_src_port;
            sip_reg   <= packet_src_ip;
            cip_reg   <= connect_ip;
            cport_reg <= connect_port;
            alen_reg  <= addr_length;
            lport_reg <= listen_port;
            close_reg <= close_slot;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/core/udp_port_demux_table.sv =====
`timescale 1ns / 1ps
// Top level of the UDP port demux table: config register, sequencer, slot memory.
// Depends on udt_pkg, udt_ctrl and udt_slot_mem.
//
// A request is taken when start is high and busy is low; busy stays high until
// the request is finished. Its result appears on the output ports for exactly
// one cycle with done high, the first cycle with busy low again, and cannot be
// held off, so the receiver must capture it then. Connect and listen step through
// the slot flags one slot a cycle up to the first free slot, and fail when the
// table is full. Deliver reads the slot memory one entry a cycle through its
// single read port up to the first used slot whose port matches, or to the end.
// A new request may be started in the same cycle as done. Write
// ephemeral_port_base through cfg_wr_en/cfg_wr_data only while busy is low.
module udp_port_demux_table #(
    parameter int SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [15:0] packet_dest_port,
    input  logic [15:0] packet_src_port,
    input  logic [31:0] packet_src_ip,
    input  logic [31:0] connect_ip,
    input  logic [15:0] connect_port,
    input  logic [7:0]  addr_length,
    input  logic [15:0] listen_port,
    input  logic [2:0]  close_slot,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  slot,
    output logic [15:0] own_port,
    output logic [31:0] peer_ip,
    output logic [15:0] peer_port
);
    import udt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [15:0]      base_reg;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_entry_t      mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    slot_entry_t      mem_rd_data;
    result_t          result;

    // Ephemeral port base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 16'd1024;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    udt_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .port_base        (base_reg),
        .req_type         (req_type),
        .packet_dest_port (packet_dest_port),
        .packet_src_port  (packet_src_port),
        .packet_src_ip    (packet_src_ip),
        .connect_ip       (connect_ip),
        .connect_port     (connect_port),
        .addr_length      (addr_length),
        .listen_port      (listen_port),
        .close_slot       (close_slot),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data),
        .done             (done),
        .result           (result)
    );

    udt_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Result transaction fields
    assign status    = result.status;
    assign slot      = result.slot;
    assign own_port  = result.own_port;
    assign peer_ip   = result.peer_ip;
    assign peer_port = result.peer_port;

endmodule

// ===== rtl/core/udt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the UDP port demux table, bound to the top level.
// Depends on udt_pkg and udp_port_demux_table.
module udt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [2:0]  slot,
    input logic [15:0] own_port,
    input logic [31:0] peer_ip,
    input logic [15:0] peer_port
);
    import udt_pkg::*;

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // A result closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result not at end of busy period");

    // Failed requests carry zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |->
            slot == 3'd0 && own_port == 16'd0 && peer_ip == 32'd0 && peer_port == 16'd0)
        else $error("failed request with nonzero fields");

    // Busy ends only with a result
    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without result");

endmodule

bind udp_port_demux_table udt_checker u_udt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .slot      (slot),
    .own_port  (own_port),
    .peer_ip   (peer_ip),
    .peer_port (peer_port)
);
